/* sv/kstt_pkg.sv */
package kstt_pkg;

  // Field widths fixed by the interface
  localparam int KEY_W   = 22;
  localparam int DELTA_W = 16;
  localparam int SCORE_W = 32;
  localparam int THR_W   = 31;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam logic [THR_W-1:0] KILL_LEVEL_RESET = THR_W'(80);

  // Configuration register byte offsets
  localparam logic [1:0] ADDR_KILL_LEVEL = 2'd0;

  // Function codes
  typedef enum logic {
    FUNC_ACCUM = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_t;

  // Item as it travels down the cell row
  typedef struct packed {
    logic                      vld;
    func_t                     func;
    logic [KEY_W-1:0]          key;
    logic signed [DELTA_W-1:0] delta;
    logic                      hit;    // entry found or appended upstream
    logic                      app;    // entry was appended
    logic signed [SCORE_W-1:0] score;  // entry score after the update
  } token_t;

  // Signed add of the delta, clamped to the 32-bit limits
  function automatic logic signed [SCORE_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [DELTA_W-1:0] d
  );
    logic signed [SCORE_W:0] sum;
    logic signed [SCORE_W-1:0] res;
    sum = {a[SCORE_W-1], a} + {{(SCORE_W + 1 - DELTA_W){d[DELTA_W-1]}}, d};
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      res = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      res = sum[SCORE_W-1:0];
    end
    return res;
  endfunction

endpackage

/* sv/kstt_cell.sv */
module kstt_cell #(
  parameter int CELL_INDEX = 0,
  parameter int CNT_W      = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  used,
  input  kstt_pkg::token_t  tok_i,
  output kstt_pkg::token_t  tok_o
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_INDEX);

  logic [kstt_pkg::KEY_W-1:0]          key_r;
  logic [kstt_pkg::KEY_W-1:0]          key_nxt;
  logic signed [kstt_pkg::SCORE_W-1:0] score_r;
  logic signed [kstt_pkg::SCORE_W-1:0] score_nxt;
  logic signed [kstt_pkg::SCORE_W-1:0] base;
  logic signed [kstt_pkg::SCORE_W-1:0] upd;
  kstt_pkg::token_t                    tok_r;
  kstt_pkg::token_t                    tok_nxt;
  logic                                occupied;
  logic                                match;
  logic                                append;

  assign occupied = (MY_IDX < used);
  assign match    = tok_i.vld && !tok_i.hit && occupied && (key_r == tok_i.key);
  assign append   = tok_i.vld && !tok_i.hit && (MY_IDX == used);

  // New score: cleared, or stored (zero for a fresh entry) plus delta
  assign base = match ? score_r : '0;
  assign upd  = (tok_i.func == kstt_pkg::FUNC_CLEAR) ? '0 : kstt_pkg::sat_add(base, tok_i.delta);

  // Match and append never coincide; most cycles see neither
  always_comb begin
    key_nxt   = key_r;
    score_nxt = score_r;
    tok_nxt   = tok_i;
    if (match) begin
      score_nxt     = upd;
      tok_nxt.hit   = 1'b1;
      tok_nxt.score = upd;
    end else if (append) begin
      key_nxt       = tok_i.key;
      score_nxt     = upd;
      tok_nxt.hit   = 1'b1;
      tok_nxt.app   = 1'b1;
      tok_nxt.score = upd;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    score_r <= score_nxt;
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

/* sv/keyed_score_table_threshold_core.sv */
// Keyed score table: up to TABLE_DEPTH process ids, each with a saturating
// signed 32-bit score. Raise start with the item fields while busy is low;
// the item walks a row of TABLE_DEPTH cells, one cell per clock, and its
// result is driven on the out_ ports for exactly one cycle, marked by
// out_strobe, from the result registers behind the last cell. One item is in
// flight at a time, and busy drops in the cycle the result is shown, so a new
// item cannot be taken before the last one has left the cell row. The receiver
// cannot stall and must take each result when out_strobe is high. Write the
// kill level only while busy is low.
module keyed_score_table_threshold_core #(
  parameter int TABLE_DEPTH = kstt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [kstt_pkg::KEY_W-1:0]          in_proc_id,
  input  logic signed [kstt_pkg::DELTA_W-1:0] in_score_delta,
  // result channel
  output logic                                out_strobe,
  output logic signed [kstt_pkg::SCORE_W-1:0] out_score_now,
  output logic                                out_kill_flag,
  output logic                                out_table_full,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [1:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  logic [kstt_pkg::THR_W-1:0] thr_r;
  logic [CNT_W-1:0]           used_r;
  logic                       busy_r;
  logic                       strobe_r;
  logic signed [kstt_pkg::SCORE_W-1:0] score_r;
  logic                       kill_r;
  logic                       full_r;
  kstt_pkg::token_t           chain [0:TABLE_DEPTH];
  kstt_pkg::token_t           last;
  logic                       accept;
  logic signed [kstt_pkg::SCORE_W-1:0] fin_score;
  logic                       fin_kill;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr == kstt_pkg::ADDR_KILL_LEVEL) ? {1'b0, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= kstt_pkg::KILL_LEVEL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      thr_r <= pwdata[kstt_pkg::THR_W-1:0];
    end
  end

  // Item entry into the cell row
  assign accept = start && !busy_r;

  always_comb begin
    chain[0]       = '0;
    chain[0].vld   = accept;
    chain[0].func  = kstt_pkg::func_t'(in_func);
    chain[0].key   = in_proc_id;
    chain[0].delta = in_score_delta;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    kstt_cell #(
      .CELL_INDEX (g),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .used  (used_r),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  assign last = chain[TABLE_DEPTH];

  // Final result: no hit means the table was full
  assign fin_score = last.hit ? last.score : '0;
  assign fin_kill  = (last.func == kstt_pkg::FUNC_ACCUM) && !fin_score[kstt_pkg::SCORE_W-1]
                     && (fin_score[kstt_pkg::THR_W-1:0] >= thr_r);

  // Control: busy flag, fill count, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      used_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= last.vld;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (last.vld) begin
        busy_r <= 1'b0;
      end
      if (last.vld && last.app) begin
        used_r <= used_r + CNT_W'(1);
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (last.vld) begin
      score_r <= fin_score;
      kill_r  <= fin_kill;
      full_r  <= !last.hit;
    end
  end

  assign busy           = busy_r;
  assign out_strobe     = strobe_r;
  assign out_score_now  = score_r;
  assign out_kill_flag  = kill_r;
  assign out_table_full = full_r;

  // Checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_C)
    else $error("fill count beyond table depth");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_table_full) |-> (out_score_now == '0))
    else $error("full table reported a nonzero score");

  a_kill_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kill_flag) |-> !out_score_now[kstt_pkg::SCORE_W-1])
    else $error("kill flag with negative score");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after start transfer");

endmodule

/* sim/testbench.sv */
module testbench;

  localparam int DEPTH           = kstt_pkg::TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 256;
  localparam int DIRECTED_COUNT  = 13;
  localparam longint SCORE_MAX   = 64'sd2147483647;
  localparam longint SCORE_MIN   = -64'sd2147483648;

  // One result as the block reports it
  typedef struct packed {
    logic signed [kstt_pkg::SCORE_W-1:0] score;
    logic                                kill;
    logic                                full;
  } score_rec_t;

  // One row of the directed stimulus; want is used only where typed is set
  typedef struct packed {
    kstt_pkg::func_t                     func;
    logic [kstt_pkg::KEY_W-1:0]          id;
    logic signed [kstt_pkg::DELTA_W-1:0] delta;
    logic                                typed;
    score_rec_t                          want;
  } stim_row_t;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic                                in_func;
  logic [kstt_pkg::KEY_W-1:0]          in_proc_id;
  logic signed [kstt_pkg::DELTA_W-1:0] in_score_delta;
  logic                                out_strobe;
  logic signed [kstt_pkg::SCORE_W-1:0] out_score_now;
  logic                                out_kill_flag;
  logic                                out_table_full;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [1:0]                          paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;

  keyed_score_table_threshold_core #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_proc_id    (in_proc_id),
    .in_score_delta(in_score_delta),
    .out_strobe    (out_strobe),
    .out_score_now (out_score_now),
    .out_kill_flag (out_kill_flag),
    .out_table_full(out_table_full),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow copy of the score table and threshold
  logic [kstt_pkg::KEY_W-1:0]          shadow_ids [DEPTH];
  logic signed [kstt_pkg::SCORE_W-1:0] shadow_scores [DEPTH];
  int                                  shadow_used;
  logic [kstt_pkg::THR_W-1:0]          shadow_threshold;

  score_rec_t                 pending_scores [$];
  logic [kstt_pkg::KEY_W-1:0] known_ids [$];
  int                         mismatch_count = 0;
  int                         cycle_count = 0;

  // Directed rows, run under the reset threshold of 80
  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    '{kstt_pkg::FUNC_ACCUM, 22'h000000, 16'h0000, 1'b1, '{32'sd0,      1'b0, 1'b0}},
    '{kstt_pkg::FUNC_ACCUM, 22'h000000, 16'h7FFF, 1'b1, '{32'sd32767,  1'b1, 1'b0}},
    '{kstt_pkg::FUNC_ACCUM, 22'h3FFFFF, 16'h8000, 1'b1, '{-32'sd32768, 1'b0, 1'b0}},
    '{kstt_pkg::FUNC_ACCUM, 22'h3FFFFF, 16'h8000, 1'b0, '{32'sd0,      1'b0, 1'b0}},
    '{kstt_pkg::FUNC_CLEAR, 22'h000000, 16'h1234, 1'b1, '{32'sd0,      1'b0, 1'b0}},
    '{kstt_pkg::FUNC_CLEAR, 22'h2AAAAA, 16'h0000, 1'b1, '{32'sd0,      1'b0, 1'b0}},
    '{kstt_pkg::FUNC_ACCUM, 22'h155555, 16'h0050, 1'b1, '{32'sd80,     1'b1, 1'b0}},
    '{kstt_pkg::FUNC_ACCUM, 22'h155555, 16'hFFFF, 1'b1, '{32'sd79,     1'b0, 1'b0}},
    '{kstt_pkg::FUNC_ACCUM, 22'h155555, 16'h5555, 1'b0, '{32'sd0,      1'b0, 1'b0}},
    '{kstt_pkg::FUNC_ACCUM, 22'h2AAAAA, 16'hAAAA, 1'b0, '{32'sd0,      1'b0, 1'b0}},
    '{kstt_pkg::FUNC_CLEAR, 22'h3FFFFF, 16'h7FFF, 1'b1, '{32'sd0,      1'b0, 1'b0}},
    '{kstt_pkg::FUNC_ACCUM, 22'h3FFFFF, 16'h0001, 1'b1, '{32'sd1,      1'b0, 1'b0}},
    '{kstt_pkg::FUNC_ACCUM, 22'h000000, 16'h0050, 1'b1, '{32'sd80,     1'b1, 1'b0}}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Find or append the id, apply the function, return what the block reports
  function automatic score_rec_t score_table_update(kstt_pkg::func_t f,
                                                    logic [kstt_pkg::KEY_W-1:0] id,
                                                    logic signed [kstt_pkg::DELTA_W-1:0] d);
    score_rec_t r;
    int         slot;
    longint     sum;
    r = '0;
    slot = -1;
    for (int i = 0; i < shadow_used; i++) begin
      if (slot < 0 && shadow_ids[i] == id) slot = i;
    end
    if (slot < 0 && shadow_used < DEPTH) begin
      slot = shadow_used;
      shadow_ids[slot] = id;
      shadow_scores[slot] = '0;
      shadow_used++;
    end
    if (slot < 0) begin
      // table full: reported score is 0, so kill only with a zero threshold
      r.full = 1'b1;
      r.kill = (f == kstt_pkg::FUNC_ACCUM) && (shadow_threshold == '0);
    end else if (f == kstt_pkg::FUNC_ACCUM) begin
      sum = longint'(shadow_scores[slot]) + longint'(d);
      if (sum > SCORE_MAX) sum = SCORE_MAX;
      if (sum < SCORE_MIN) sum = SCORE_MIN;
      shadow_scores[slot] = sum[kstt_pkg::SCORE_W-1:0];
      r.score = sum[kstt_pkg::SCORE_W-1:0];
      r.kill = (sum >= 0) && (sum >= longint'(shadow_threshold));
    end else begin
      shadow_scores[slot] = '0;
    end
    return r;
  endfunction

  // Present one item and hold it until the start transfer
  task automatic send_item(kstt_pkg::func_t f, logic [kstt_pkg::KEY_W-1:0] id,
                           logic signed [kstt_pkg::DELTA_W-1:0] d,
                           logic typed, score_rec_t want);
    score_rec_t predicted;
    start          <= 1'b1;
    in_func        <= f;
    in_proc_id     <= id;
    in_score_delta <= d;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = score_table_update(f, id, d);
    pending_scores.push_back(typed ? want : predicted);
  endtask

  task automatic write_threshold(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= kstt_pkg::ADDR_KILL_LEVEL;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_threshold = value[kstt_pkg::THR_W-1:0];
  endtask

  task automatic check_threshold_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= kstt_pkg::ADDR_KILL_LEVEL;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[kstt_pkg::THR_W-1:0] !== shadow_threshold)
      log_mismatch($sformatf("kill level read expected %0d got %0d",
                             shadow_threshold, prdata[kstt_pkg::THR_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result checker: every strobe takes the oldest expectation
  always @(posedge clk) begin
    score_rec_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_scores.size() == 0) begin
        log_mismatch($sformatf("unexpected result score %0d kill %0b full %0b",
                               out_score_now, out_kill_flag, out_table_full));
      end else begin
        want = pending_scores.pop_front();
        if (out_score_now !== want.score || out_kill_flag !== want.kill ||
            out_table_full !== want.full)
          log_mismatch($sformatf(
            "expected score %0d kill %0b full %0b, got score %0d kill %0b full %0b",
            want.score, want.kill, want.full,
            out_score_now, out_kill_flag, out_table_full));
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0]                         thr_plan [PHASES];
    logic [kstt_pkg::KEY_W-1:0]          id;
    logic signed [kstt_pkg::DELTA_W-1:0] d;
    kstt_pkg::func_t                     f;
    int                                  tmp;
    int                                  fresh_pct;
    int                                  item_number;
    logic                                idling;

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_func        <= 1'b0;
    in_proc_id     <= '0;
    in_score_delta <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    shadow_used      = 0;
    shadow_threshold = kstt_pkg::KILL_LEVEL_RESET;
    idling           = 1'b0;
    item_number      = 0;

    // Threshold per phase; phase 0 keeps the reset value.
    // Zero thresholds sit late, after the table has filled.
    thr_plan[0] = 32'd80;
    thr_plan[1] = 32'h7FFF_FFFF;
    thr_plan[2] = $urandom_range(0, 100000);
    thr_plan[3] = 32'd0;
    thr_plan[4] = $urandom;
    thr_plan[5] = 32'd1;
    thr_plan[6] = 32'd0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_threshold_readback();
    @(posedge clk);

    // Directed part: field extremes, both functions, threshold boundary
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      known_ids.push_back(directed_rows[i].id);
      send_item(directed_rows[i].func, directed_rows[i].id, directed_rows[i].delta,
                directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part. Scores stay far from the 32-bit clamps: reaching one takes
    // some 65k max-size steps on a single id.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        start <= 1'b0;
        while (pending_scores.size() != 0) @(posedge clk);
        write_threshold(thr_plan[phase]);
        @(posedge clk);
        check_threshold_readback();
        @(posedge clk);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 32 == 0) idling = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
        if (idling && $urandom_range(0, 2) == 0) begin
          start <= 1'b0;
          // sometimes hold off until the current item has finished
          if ($urandom_range(0, 1) == 1) begin
            @(posedge clk);
            while (busy !== 1'b0) @(posedge clk);
          end
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end

        // early on, many new ids so the table fills; later mostly known ones
        fresh_pct = (item_number < 600) ? 25 : 5;
        if ($urandom_range(0, 99) < fresh_pct) begin
          case ($urandom_range(0, 9))
            0:       id = '0;
            1:       id = '1;
            default: id = kstt_pkg::KEY_W'($urandom_range(0, (1 << kstt_pkg::KEY_W) - 1));
          endcase
          known_ids.push_back(id);
        end else begin
          id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        end

        case ($urandom_range(0, 9))
          0:       d = 16'h7FFF;
          1:       d = 16'h8000;
          2, 3: begin
            tmp = int'($urandom_range(0, 400)) - 200;
            d = kstt_pkg::DELTA_W'(tmp);
          end
          default: d = kstt_pkg::DELTA_W'($urandom_range(0, 65535));
        endcase

        f = ($urandom_range(0, 99) < 15) ? kstt_pkg::FUNC_CLEAR : kstt_pkg::FUNC_ACCUM;
        send_item(f, id, d, 1'b0, '0);
        item_number++;
      end
    end

    // Drain
    start <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (mismatch_count == 0 && pending_scores.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // pready is an output of the block; nothing to drive here
endmodule

/* files.f */
sv/kstt_pkg.sv
sv/kstt_cell.sv
sv/keyed_score_table_threshold_core.sv
sim/testbench.sv
